// File: sv/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EFSG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define EFSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: sv/efsg_pkg.sv
// Shared constants, command and status types of the ellipse fill span generator.
`default_nettype none

package efsg_pkg;

  // Geometry limits.
  localparam int unsigned MaxDim     = 31;
  localparam int unsigned MaxResults = 33;
  localparam int unsigned ThinLim    = 3;

  // Field and datapath widths.
  localparam int unsigned CoordW = 16;  // signed coordinates, wrap at 16 bits
  localparam int unsigned SizeW  = 15;  // box and span sizes
  localparam int unsigned HalfW  = 14;  // half axes a and b
  localparam int unsigned SqW    = 2 * HalfW;  // a*a and b*b
  localparam int unsigned PosW   = 16;  // walk position along x, may pass a
  localparam int unsigned ErrW   = 40;  // midpoint error terms, signed
  localparam int unsigned CntW   = $clog2(MaxResults + 1);

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_A2,
    MUL_B2,
    MUL_AB
  } mul_op_e;

  // Which rectangle the output register is loaded with.
  typedef enum logic [2:0] {
    EMIT_SINGLE,
    EMIT_CENTER,
    EMIT_RUN_TOP,
    EMIT_RUN_BOT,
    EMIT_TAIL_TOP,
    EMIT_TAIL_BOT
  } emit_kind_e;

  typedef struct packed {
    logic       load;
    mul_op_e    mul_op;
    logic       init;
    logic       step;
    logic       clr_pending;
    logic       emit;
    emit_kind_e emit_kind;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic over;
    logic thin;
    logic wodd;
    logic loop_done;
    logic flush_needed;
    logic tail_needed;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: sv/efsg_if.sv
// Valid/ready channel interfaces for boxes in and fill rectangles out.
`default_nettype none

interface efsg_box_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] box_x;
  logic signed [15:0] box_y;
  logic        [14:0] box_width;
  logic        [14:0] box_height;

  modport source (output valid, box_x, box_y, box_width, box_height, input ready);
  modport sink   (input valid, box_x, box_y, box_width, box_height, output ready);
endinterface

interface efsg_span_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] span_x;
  logic signed [15:0] span_y;
  logic        [14:0] span_width;
  logic        [14:0] span_height;
  logic               last_span;
  logic               oversize;

  modport source (output valid, span_x, span_y, span_width, span_height, last_span,
                  oversize, input ready);
  modport sink   (input valid, span_x, span_y, span_width, span_height, last_span,
                  oversize, output ready);
endinterface

`default_nettype wire

// File: sv/efsg_ctrl.sv
// Sequencer of the ellipse fill span generator: setup, midpoint walk and emission.
`default_nettype none

module efsg_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          box_valid_i,
  output logic               box_ready_o,
  input  wire efsg_pkg::sts_t sts_i,
  output efsg_pkg::cmd_t     cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL_A    = 4'd1;
  localparam logic [3:0] S_MUL_B    = 4'd2;
  localparam logic [3:0] S_MUL_AB   = 4'd3;
  localparam logic [3:0] S_INIT     = 4'd4;
  localparam logic [3:0] S_SINGLE   = 4'd5;
  localparam logic [3:0] S_CENTER   = 4'd6;
  localparam logic [3:0] S_LOOP     = 4'd7;
  localparam logic [3:0] S_RUN_TOP  = 4'd8;
  localparam logic [3:0] S_RUN_BOT  = 4'd9;
  localparam logic [3:0] S_FIN_TOP  = 4'd10;
  localparam logic [3:0] S_FIN_BOT  = 4'd11;
  localparam logic [3:0] S_TAIL_TOP = 4'd12;
  localparam logic [3:0] S_TAIL_BOT = 4'd13;

  localparam int unsigned CW = efsg_pkg::CntW;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          cap;

  // The result that reaches the output limit closes the box.
  assign cap = (cnt_q == CW'(efsg_pkg::MaxResults - 1));

  always_comb begin
    state_d           = state_q;
    cnt_d             = cnt_q;
    box_ready_o       = 1'b0;
    cmd_o             = '0;
    cmd_o.mul_op      = efsg_pkg::MUL_IDLE;
    cmd_o.emit_kind   = efsg_pkg::EMIT_SINGLE;

    case (state_q)
      S_IDLE: begin
        box_ready_o = 1'b1;
        if (box_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_MUL_A;
        end
      end
      S_MUL_A: begin
        cmd_o.mul_op = efsg_pkg::MUL_A2;
        state_d      = (sts_i.over || sts_i.thin) ? S_SINGLE : S_MUL_B;
      end
      S_MUL_B: begin
        cmd_o.mul_op = efsg_pkg::MUL_B2;
        state_d      = S_MUL_AB;
      end
      S_MUL_AB: begin
        cmd_o.mul_op = efsg_pkg::MUL_AB;
        state_d      = S_INIT;
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = sts_i.wodd ? S_LOOP : S_CENTER;
      end
      S_SINGLE: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = efsg_pkg::EMIT_SINGLE;
          cmd_o.last      = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_CENTER: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = efsg_pkg::EMIT_CENTER;
          cnt_d           = cnt_q + 1'b1;
          state_d         = S_LOOP;
        end
      end
      S_LOOP: begin
        if (sts_i.loop_done) begin
          state_d = S_FIN_TOP;
        end else if (sts_i.flush_needed) begin
          state_d = S_RUN_TOP;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_RUN_TOP, S_FIN_TOP: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = efsg_pkg::EMIT_RUN_TOP;
          cmd_o.last      = cap;
          cnt_d           = cnt_q + 1'b1;
          if (cap) begin
            state_d = S_IDLE;
          end else begin
            state_d = (state_q == S_RUN_TOP) ? S_RUN_BOT : S_FIN_BOT;
          end
        end
      end
      S_RUN_BOT: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_kind   = efsg_pkg::EMIT_RUN_BOT;
          cmd_o.clr_pending = 1'b1;
          cmd_o.last        = cap;
          cnt_d             = cnt_q + 1'b1;
          state_d           = cap ? S_IDLE : S_LOOP;
        end
      end
      S_FIN_BOT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = efsg_pkg::EMIT_RUN_BOT;
          cmd_o.last      = cap || !sts_i.tail_needed;
          cnt_d           = cnt_q + 1'b1;
          state_d         = (cap || !sts_i.tail_needed) ? S_IDLE : S_TAIL_TOP;
        end
      end
      S_TAIL_TOP: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = efsg_pkg::EMIT_TAIL_TOP;
          cmd_o.last      = cap;
          cnt_d           = cnt_q + 1'b1;
          state_d         = cap ? S_IDLE : S_TAIL_BOT;
        end
      end
      S_TAIL_BOT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = efsg_pkg::EMIT_TAIL_BOT;
          cmd_o.last      = 1'b1;
          cnt_d           = cnt_q + 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/efsg_datapath.sv
// Datapath: box registers, shared multiplier, midpoint walk and output register.
`default_nettype none

module efsg_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire efsg_pkg::cmd_t     cmd_i,
  output efsg_pkg::sts_t          sts_o,
  input  wire logic signed [15:0] box_x_i,
  input  wire logic signed [15:0] box_y_i,
  input  wire logic        [14:0] box_width_i,
  input  wire logic        [14:0] box_height_i,
  input  wire logic               span_ready_i,
  output logic                    span_valid_o,
  output logic signed [15:0]      span_x_o,
  output logic signed [15:0]      span_y_o,
  output logic        [14:0]      span_width_o,
  output logic        [14:0]      span_height_o,
  output logic                    last_span_o,
  output logic                    oversize_o
);

  localparam int unsigned EW = efsg_pkg::ErrW;
  localparam int unsigned CW = efsg_pkg::CoordW;
  localparam int unsigned ZW = efsg_pkg::SizeW;
  localparam int unsigned HW = efsg_pkg::HalfW;
  localparam int unsigned QW = efsg_pkg::SqW;
  localparam int unsigned PW = efsg_pkg::PosW;

  // Box registers.
  logic [CW-1:0] bx_q, by_q;
  logic [ZW-1:0] w_q, h_q;
  logic [HW-1:0] a, b;

  // Setup products.
  logic [QW-1:0]        a2_q, b2_q;
  logic signed [EW-1:0] ab_q;
  logic [QW-1:0]        mul_l;
  logic [HW-1:0]        mul_r;
  logic [QW+HW-1:0]     prod;

  // Walk state.
  logic signed [EW-1:0] et_q, sx_q, sy_q, p_q, q_q, xcrit_q, ycrit_q;
  logic [PW-1:0]        pos_x_q, rhw_q;
  logic [HW-1:0]        pos_y_q, rtop_q, rh_q;
  logic                 pending_q;

  logic signed [EW-1:0] a2_s, b2_s, a3_s, b3_s, d2x, d2y;
  logic                 go_x, go_y;

  // Output register.
  logic                 out_valid_q;
  logic [CW-1:0]        ox_q, oy_q, ox_d, oy_d;
  logic [ZW-1:0]        ow_q, oh_q, ow_d, oh_d;
  logic                 olast_q, oover_q, oover_d;

  logic [CW-1:0] a16, b16, cx, cy, hodd16, rtop16, rh16, py16, hw2, a2x;

  assign a = w_q[ZW-1:1];
  assign b = h_q[ZW-1:1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bx_q <= box_x_i;
      by_q <= box_y_i;
      w_q  <= box_width_i;
      h_q  <= box_height_i;
    end
  end

  // One shared multiplier, one product per setup cycle.
  always_comb begin
    case (cmd_i.mul_op)
      efsg_pkg::MUL_A2: begin
        mul_l = QW'(a);
        mul_r = a;
      end
      efsg_pkg::MUL_B2: begin
        mul_l = QW'(b);
        mul_r = b;
      end
      efsg_pkg::MUL_AB: begin
        mul_l = a2_q;
        mul_r = b;
      end
      default: begin
        mul_l = '0;
        mul_r = '0;
      end
    endcase
  end

  assign prod = mul_l * mul_r;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_op == efsg_pkg::MUL_A2) a2_q <= prod[QW-1:0];
    if (cmd_i.mul_op == efsg_pkg::MUL_B2) b2_q <= prod[QW-1:0];
    if (cmd_i.mul_op == efsg_pkg::MUL_AB) ab_q <= signed'(prod[EW-1:0]);
  end

  assign a2_s = signed'(EW'(a2_q));
  assign b2_s = signed'(EW'(b2_q));
  assign a3_s = (a2_s <<< 1) + a2_s;
  assign b3_s = (b2_s <<< 1) + b2_s;
  assign d2x  = b2_s <<< 1;
  assign d2y  = a2_s <<< 1;

  // p tracks a2*pos_y and q tracks b2*pos_x, so the walk needs no multiplier.
  assign go_x = (et_q + p_q) < xcrit_q;
  assign go_y = (et_q - q_q) >= ycrit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      et_q    <= b2_s + a2_s - (ab_q <<< 1);
      sx_q    <= b3_s;
      sy_q    <= a3_s - (ab_q <<< 1);
      xcrit_q <= (a3_s >>> 2) + EW'(1);
      ycrit_q <= (b3_s >>> 2) + EW'(1);
      p_q     <= ab_q;
      q_q     <= '0;
      pos_x_q <= '0;
      pos_y_q <= b;
      rhw_q   <= '0;
      rtop_q  <= '0;
      rh_q    <= '0;
    end else if (cmd_i.step) begin
      if (pending_q) begin
        rh_q <= rh_q + 1'b1;
      end else if (!go_x) begin
        rhw_q  <= pos_x_q;
        rtop_q <= pos_y_q;
        rh_q   <= HW'(1);
      end
      if (go_x) begin
        pos_x_q <= pos_x_q + 1'b1;
        q_q     <= q_q + b2_s;
        et_q    <= et_q + sx_q;
        sx_q    <= sx_q + d2x;
      end else if (go_y) begin
        pos_y_q <= pos_y_q - 1'b1;
        p_q     <= p_q - a2_s;
        et_q    <= et_q + sy_q;
        sy_q    <= sy_q + d2y;
      end else begin
        pos_x_q <= pos_x_q + 1'b1;
        pos_y_q <= pos_y_q - 1'b1;
        q_q     <= q_q + b2_s;
        p_q     <= p_q - a2_s;
        et_q    <= et_q + sx_q + sy_q;
        sx_q    <= sx_q + d2x;
        sy_q    <= sy_q + d2y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else if (cmd_i.init || cmd_i.clr_pending) begin
      pending_q <= 1'b0;
    end else if (cmd_i.step && !go_x) begin
      pending_q <= 1'b1;
    end
  end

  // Rectangle geometry, all coordinates wrap at 16 bits.
  assign a16    = CW'(a);
  assign b16    = CW'(b);
  assign cx     = bx_q + a16;
  assign cy     = by_q + b16;
  assign hodd16 = CW'(h_q[0]);
  assign rtop16 = CW'(rtop_q);
  assign rh16   = CW'(rh_q);
  assign py16   = CW'(pos_y_q);
  assign hw2    = CW'({rhw_q[PW-2:0], w_q[0]});
  assign a2x    = CW'({a16[CW-2:0], w_q[0]});

  always_comb begin
    ox_d    = '0;
    oy_d    = '0;
    ow_d    = '0;
    oh_d    = '0;
    oover_d = 1'b0;
    case (cmd_i.emit_kind)
      efsg_pkg::EMIT_SINGLE: begin
        if (!sts_o.over) begin
          ox_d = bx_q;
          oy_d = by_q;
          ow_d = w_q;
          oh_d = h_q;
        end
        oover_d = sts_o.over;
      end
      efsg_pkg::EMIT_CENTER: begin
        ox_d = cx - CW'(1);
        oy_d = cy - b16;
        ow_d = ZW'(2);
        oh_d = h_q;
      end
      efsg_pkg::EMIT_RUN_TOP: begin
        ox_d = cx - rhw_q;
        oy_d = cy - rtop16;
        ow_d = hw2[ZW-1:0];
        oh_d = ZW'(rh_q);
      end
      efsg_pkg::EMIT_RUN_BOT: begin
        ox_d = cx - rhw_q;
        oy_d = cy + rtop16 + hodd16 - rh16;
        ow_d = hw2[ZW-1:0];
        oh_d = ZW'(rh_q);
      end
      efsg_pkg::EMIT_TAIL_TOP: begin
        ox_d = cx - a16;
        oy_d = cy - py16;
        ow_d = a2x[ZW-1:0];
        oh_d = ZW'(1);
      end
      efsg_pkg::EMIT_TAIL_BOT: begin
        ox_d = cx - a16;
        oy_d = cy + py16 - CW'(1) + hodd16;
        ow_d = a2x[ZW-1:0];
        oh_d = ZW'(1);
      end
      default: begin
        oover_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (span_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      ox_q    <= ox_d;
      oy_q    <= oy_d;
      ow_q    <= ow_d;
      oh_q    <= oh_d;
      olast_q <= cmd_i.last;
      oover_q <= oover_d;
    end
  end

  assign span_valid_o  = out_valid_q;
  assign span_x_o      = signed'(ox_q);
  assign span_y_o      = signed'(oy_q);
  assign span_width_o  = ow_q;
  assign span_height_o = oh_q;
  assign last_span_o   = olast_q;
  assign oversize_o    = oover_q;

  assign sts_o.over         = (w_q > ZW'(efsg_pkg::MaxDim)) && (h_q > ZW'(efsg_pkg::MaxDim));
  assign sts_o.thin         = (w_q < ZW'(efsg_pkg::ThinLim)) || (h_q < ZW'(efsg_pkg::ThinLim));
  assign sts_o.wodd         = w_q[0];
  assign sts_o.loop_done    = (pos_y_q == '0);
  assign sts_o.flush_needed = pending_q && (rhw_q != pos_x_q);
  assign sts_o.tail_needed  = (pos_x_q <= PW'(a));
  assign sts_o.out_free     = !out_valid_q || span_ready_i;

endmodule

`default_nettype wire

// File: sv/ellipse_fill_span_generator.sv
// Top level of the ellipse fill span generator: sequencer plus datapath.
//
// Usage: one bounding box is transferred on box_i (valid/ready). The block
// answers on span_o with the filled rectangles that cover the solid ellipse
// inscribed in the box, one transfer per rectangle, the final one flagged by
// last_span. A box with both sides above 31 gives a single result flagged
// oversize with zero geometry; a box with a side below 3 comes back whole.
// Flow: a degenerate box goes from S_MUL_A straight to its single emission.
// An ordinary box passes the setup states S_MUL_A, S_MUL_B and S_MUL_AB,
// all on the shared multiplier, and S_INIT, then the steps of the midpoint
// walk, about a + b steps for half axes a and b, plus one emission per
// rectangle, at most 33, and a pass through S_LOOP without a step each time
// a merged run is closed or the walk ends. The block takes one box at a
// time, so the next box is taken only once the last rectangle of the
// current one is in the output register. That register stays put while
// the receiver stalls and the sequencer holds its emission state until
// the slot frees up. Reset clears the sequencer, the output valid and the
// merge flag; the block is then idle and ready for a box.
`default_nettype none

module ellipse_fill_span_generator (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  efsg_box_if.sink      box_i,
  efsg_span_if.source   span_o
);

  efsg_pkg::cmd_t cmd;
  efsg_pkg::sts_t sts;

  // The sequencer decides what happens each cycle; the datapath only obeys.
  efsg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .box_valid_i (box_i.valid),
    .box_ready_o (box_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  efsg_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .box_x_i       (box_i.box_x),
    .box_y_i       (box_i.box_y),
    .box_width_i   (box_i.box_width),
    .box_height_i  (box_i.box_height),
    .span_ready_i  (span_o.ready),
    .span_valid_o  (span_o.valid),
    .span_x_o      (span_o.span_x),
    .span_y_o      (span_o.span_y),
    .span_width_o  (span_o.span_width),
    .span_height_o (span_o.span_height),
    .last_span_o   (span_o.last_span),
    .oversize_o    (span_o.oversize)
  );

endmodule

`default_nettype wire

// File: sv/efsg_checker.sv
// Port-level checker for the ellipse fill span generator and its bind.
`default_nettype none
`include "assert_macros.svh"

module efsg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        box_valid_i,
  input wire logic        box_ready_i,
  input wire logic        span_valid_i,
  input wire logic        span_ready_i,
  input wire logic [15:0] span_x_i,
  input wire logic [15:0] span_y_i,
  input wire logic [14:0] span_width_i,
  input wire logic [14:0] span_height_i,
  input wire logic        span_last_i,
  input wire logic        span_oversize_i
);

  // An oversize answer stands alone and carries no geometry.
  `EFSG_ASSERT_IMPLIES(a_oversize_alone, clk_i, rst_ni, span_valid_i && span_oversize_i, span_last_i && span_width_i == 15'd0 && span_height_i == 15'd0)

  // Once a box is taken the block is busy with it.
  `EFSG_ASSERT_NEXT(a_busy_after_box, clk_i, rst_ni, box_valid_i && box_ready_i, !box_ready_i)

  // Only a degenerate box, always a final result, may give zero height.
  `EFSG_ASSERT_IMPLIES(a_inner_height, clk_i, rst_ni, span_valid_i && !span_last_i, span_height_i != 15'd0 && !span_oversize_i)

  // A stalled rectangle holds.
  `EFSG_ASSERT_NEXT(a_span_hold, clk_i, rst_ni, span_valid_i && !span_ready_i, span_valid_i && $stable(span_x_i) && $stable(span_y_i) && $stable(span_last_i))

endmodule

bind ellipse_fill_span_generator efsg_checker u_efsg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .box_valid_i     (box_i.valid),
  .box_ready_i     (box_i.ready),
  .span_valid_i    (span_o.valid),
  .span_ready_i    (span_o.ready),
  .span_x_i        (span_o.span_x),
  .span_y_i        (span_o.span_y),
  .span_width_i    (span_o.span_width),
  .span_height_i   (span_o.span_height),
  .span_last_i     (span_o.last_span),
  .span_oversize_i (span_o.oversize)
);

`default_nettype wire
